[design/wstd_pkg.sv]
// ----------------------------------------------------------------------------
// Work-stealing dispatcher package
// Shared types, request and status codes, and controller/datapath bundles.
// ----------------------------------------------------------------------------
package wstd_pkg;

  localparam int unsigned MaxWorkersDef = 8;
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned HandleBitsDef = 16;
  localparam int unsigned BusyMax       = 15;

  // Request codes.
  localparam logic [1:0] ReqSubmit   = 2'd0;
  localparam logic [1:0] ReqFetch    = 2'd1;
  localparam logic [1:0] ReqComplete = 2'd2;

  // Status codes.
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StFull      = 2'd1;
  localparam logic [1:0] StNoTask    = 2'd2;
  localparam logic [1:0] StUnderflow = 2'd3;

  // Fetch source codes.
  localparam logic [1:0] SrcOwn    = 2'd0;
  localparam logic [1:0] SrcGlobal = 2'd1;
  localparam logic [1:0] SrcSteal  = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [3:0]               target_queue;
    logic [HandleBitsDef-1:0] task_handle;
    logic [2:0]               worker_id;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [HandleBitsDef-1:0] handle_out;
    logic [1:0]               source;
    logic [2:0]               victim;
    logic                     all_idle;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;  // latch request and decide
    logic finish;   // commit state and emit result
  } cmd_t;

endpackage

[design/wstd_ctrl.sv]
// ----------------------------------------------------------------------------
// Work-stealing dispatcher controller
// Two-state sequencer: an idle state that decodes each item and a commit state that follows it.
// ----------------------------------------------------------------------------
module wstd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  output wstd_pkg::cmd_t cmd_o
);
  import wstd_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StWork = 1'b1;

  logic state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (start_i) state_d = StWork;
      StWork: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  assign busy_o        = (state_q == StWork);
  assign cmd_o.capture = (state_q == StIdle) && start_i;
  assign cmd_o.finish  = (state_q == StWork);

  // A finish always follows a capture.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.finish) else $error("finish missing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> !cmd_o.finish) else $error("double finish");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.capture && cmd_o.finish)) else $error("overlap");

endmodule

[design/wstd_datapath.sv]
// ----------------------------------------------------------------------------
// Work-stealing dispatcher datapath
// Queue pointers, slot memory, steal search and busy count.
// ----------------------------------------------------------------------------
module wstd_datapath #(
  parameter int unsigned QUEUE_DEPTH = wstd_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wstd_pkg::cmd_t cmd_i,
  input  wstd_pkg::req_t req_i,
  input  logic [3:0]     act_raw_i,
  output logic           rsp_valid_o,
  output wstd_pkg::rsp_t rsp_o
);
  import wstd_pkg::*;

  localparam int unsigned MAX_WORKERS = MaxWorkersDef;
  localparam int unsigned HANDLE_BITS = HandleBitsDef;
  localparam int unsigned NQ    = MAX_WORKERS + 1;
  localparam int unsigned QW    = $clog2(NQ);
  localparam int unsigned PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW    = QW + PW;
  localparam int unsigned MEMD  = NQ * QUEUE_DEPTH;
  localparam logic [QW-1:0] GQ  = QW'(MAX_WORKERS);
  localparam logic [CW-1:0] CFULL = CW'(QUEUE_DEPTH);
  localparam logic [PW:0]   DEPTH_W = (PW+1)'(QUEUE_DEPTH);

  logic [HANDLE_BITS-1:0] mem_q [MEMD];
  logic [PW-1:0] heads_q [NQ];
  logic [CW-1:0] counts_q [NQ];
  logic [3:0]    busy_q;

  // Ring wrap of a sum below twice the depth.
  function automatic logic [PW-1:0] ring_wrap(logic [PW:0] s);
    return (s >= DEPTH_W) ? PW'(s - DEPTH_W) : PW'(s);
  endfunction

  // Effective worker count, clamped to 1..MAX_WORKERS.
  logic [7:0] act;
  always_comb begin
    priority if (act_raw_i == 4'd0) act = 8'd1;
    else if ({4'd0, act_raw_i} > 8'(MAX_WORKERS)) act = 8'(MAX_WORKERS);
    else act = {4'd0, act_raw_i};
  end

  // Decode: pick queue, action and slot in the capture cycle.
  logic [QW-1:0] q_d, q_q;
  logic [PW-1:0] pos_d, pos_q;
  logic [1:0]    st_d, st_q, src_d, src_q;
  logic          wr_d, wr_q, take_d, take_q, front_d, front_q, busy_up_d, busy_up_q;
  logic          busy_dn_d, busy_dn_q;
  logic [HANDLE_BITS-1:0] hin_q;
  logic [2:0]    vic_d, vic_q;
  logic          found_v;
  logic [QW-1:0] vidx;
  logic [QW-1:0] wq;

  always_comb begin
    found_v = 1'b0;
    vidx    = '0;
    wq      = QW'(req_i.worker_id);
    for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
      if (8'(i) < act && QW'(i) != wq && counts_q[i] != '0) begin
        found_v = 1'b1;
        vidx    = QW'(i);
      end
    end
  end

  always_comb begin
    q_d = GQ; pos_d = '0; st_d = StOk; src_d = SrcOwn; vic_d = '0;
    wr_d = 1'b0; take_d = 1'b0; front_d = 1'b1; busy_up_d = 1'b0; busy_dn_d = 1'b0;
    unique case (req_i.req_type)
      ReqSubmit: begin
        q_d = ({4'd0, req_i.target_queue} >= act) ? GQ : QW'(req_i.target_queue);
        if (counts_q[q_d] >= CFULL) st_d = StFull;
        else begin
          wr_d  = 1'b1;
          pos_d = ring_wrap({1'b0, heads_q[q_d]} + (PW+1)'(counts_q[q_d]));
        end
      end
      ReqFetch: begin
        st_d = StNoTask;
        if ({5'd0, req_i.worker_id} < act) begin
          priority if (counts_q[wq] != '0) begin
            q_d = wq; take_d = 1'b1; st_d = StOk; src_d = SrcOwn;
          end else if (counts_q[GQ] != '0) begin
            q_d = GQ; take_d = 1'b1; st_d = StOk; src_d = SrcGlobal;
          end else if (found_v) begin
            q_d = vidx; take_d = 1'b1; st_d = StOk; src_d = SrcSteal;
            front_d = 1'b0; vic_d = 3'(vidx);
          end
        end
        if (take_d) begin
          busy_up_d = 1'b1;
          pos_d = front_d ? heads_q[q_d]
                : ring_wrap({1'b0, heads_q[q_d]} + (PW+1)'(counts_q[q_d]) - (PW+1)'(1));
        end
      end
      ReqComplete: begin
        if (busy_q == 4'd0) st_d = StUnderflow;
        else busy_dn_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      q_q <= q_d; pos_q <= pos_d; st_q <= st_d; src_q <= src_d; vic_q <= vic_d;
      hin_q <= req_i.task_handle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; take_q <= 1'b0; front_q <= 1'b1; busy_up_q <= 1'b0; busy_dn_q <= 1'b0;
    end else if (cmd_i.capture) begin
      wr_q <= wr_d; take_q <= take_d; front_q <= front_d;
      busy_up_q <= busy_up_d; busy_dn_q <= busy_dn_d;
    end
  end

  // Slot memory: write on submit commit, registered read in the capture cycle.
  logic [HANDLE_BITS-1:0] rd_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && wr_q) mem_q[AW'(q_q) * AW'(QUEUE_DEPTH) + AW'(pos_q)] <= hin_q;
    if (cmd_i.capture) rd_q <= mem_q[AW'(q_d) * AW'(QUEUE_DEPTH) + AW'(pos_d)];
  end

  // Commit pointers and busy count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NQ; i++) begin
        heads_q[i]  <= '0;
        counts_q[i] <= '0;
      end
      busy_q <= '0;
    end else if (cmd_i.finish) begin
      if (wr_q) counts_q[q_q] <= counts_q[q_q] + CW'(1);
      if (take_q) begin
        counts_q[q_q] <= counts_q[q_q] - CW'(1);
        if (front_q) heads_q[q_q] <= ring_wrap({1'b0, heads_q[q_q]} + (PW+1)'(1));
      end
      if (busy_up_q && busy_q != 4'(BusyMax)) busy_q <= busy_q + 4'd1;
      if (busy_dn_q) busy_q <= busy_q - 4'd1;
    end
  end

  // Result, registered with its strobe.
  logic [CW-1:0] gcnt_next;
  logic [3:0]    busy_next;
  always_comb begin
    gcnt_next = counts_q[GQ];
    if (wr_q && q_q == GQ) gcnt_next = gcnt_next + CW'(1);
    if (take_q && q_q == GQ) gcnt_next = gcnt_next - CW'(1);
    busy_next = busy_q;
    if (busy_up_q && busy_q != 4'(BusyMax)) busy_next = busy_q + 4'd1;
    if (busy_dn_q) busy_next = busy_q - 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rsp_valid_o <= 1'b0;
    else rsp_valid_o <= cmd_i.finish;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rsp_o.status     <= st_q;
      rsp_o.handle_out <= take_q ? rd_q : '0;
      rsp_o.source     <= take_q ? src_q : SrcOwn;
      rsp_o.victim     <= take_q ? vic_q : 3'd0;
      rsp_o.all_idle   <= (gcnt_next == '0) && (busy_next == 4'd0);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !(wr_q && take_q)) else $error("write and take together");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && take_q |-> counts_q[q_q] != '0) else $error("take from empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && wr_q |-> counts_q[q_q] < CFULL) else $error("write to full");

endmodule

[design/work_stealing_task_dispatcher.sv]
// ----------------------------------------------------------------------------
// Work-stealing task dispatcher
// Per-worker queues plus a global queue with fetch, steal and busy count.
// ----------------------------------------------------------------------------
// The result strobe is registered from the commit state, which follows the start transfer.
// A new start is not taken while busy; busy is high the cycle after start,
// while the controller is in its commit state.
// The receiver cannot stall; every result is shown for one cycle.
// Reset clears pointers, counts and busy count, and sets active workers to 8.
// The slot memory has no reset; only written slots are ever returned.
module work_stealing_task_dispatcher #(
  parameter int unsigned QUEUE_DEPTH = wstd_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  wstd_pkg::req_t req_i,
  output logic           done_o,
  output wstd_pkg::rsp_t rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [3:0]     cfg_data_i
);
  import wstd_pkg::*;

  cmd_t       cmd;
  logic [3:0] act_q;

  // Configuration register transfer.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) act_q <= 4'd8;
    else if (cfg_valid_i) act_q <= cfg_data_i;
  end

  wstd_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .cmd_o(cmd)
  );

  wstd_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .req_i, .act_raw_i(act_q),
    .rsp_valid_o(done_o), .rsp_o
  );

endmodule
